FILE: src/twfct_pkg.sv
// Shared types and codes for the two-way FIFO cache tracker.
package twfct_pkg;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK
	} twfct_state_t;

	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_TWO_WAY   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INDEX     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WR_ALLOC  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_WR_BACK   = 3'd4;

	localparam int CFG_DATA_W = 5;

	localparam logic CMD_READ  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	// One finished access, as seen by the statistics counters
	typedef struct packed {
		logic fire;
		logic is_write;
		logic hit;
		logic evicted;
		logic memw;
	} twfct_event_t;

endpackage

FILE: src/two_way_fifo_cache_tracker.sv
// Top level: cache tag controller with per-set FIFO victim selection.
// Each access reads the set row (both ways' tags, valid and dirty bits,
// victim bit) from the set RAM in the start cycle; the row is then compared,
// updated and written back in the next, with busy high in that cycle, and
// done pulses for one cycle after it with the result and updated counters. A
// new start is not taken while busy is high. There is no back-pressure on the
// result side: the receiver cannot stall and must take each result in its done
// cycle. After reset a clearing pass writes every set row with busy held high;
// the configuration port is always ready and is meant to be written while
// idle.
module two_way_fifo_cache_tracker
	import twfct_pkg::*;
#(
	parameter int MAX_INDEX_BITS = 10,
	parameter int ADDRESS_WIDTH  = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 cmd,
	input  logic [31:0]          address,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                 done,
	output logic                 hit,
	output logic                 way_used,
	output logic                 evicted_dirty,
	output logic                 memory_write,
	output logic [31:0]          read_hit_count,
	output logic [31:0]          write_hit_count,
	output logic [31:0]          read_miss_count,
	output logic [31:0]          write_miss_count,
	output logic [31:0]          writeback_count,
	output logic [31:0]          memory_write_count
);

	localparam int AW     = ADDRESS_WIDTH;
	localparam int SET_AW = (MAX_INDEX_BITS > 0) ? MAX_INDEX_BITS : 1;

	typedef struct packed {
		logic                victim;
		logic [1:0]          dirty;
		logic [1:0]          valid;
		logic [1:0][AW-1:0]  tag;
	} row_t;

	localparam int RW = $bits(row_t);

	twfct_state_t state_q, state_d;

	// configuration
	logic       two_way_q;
	logic [4:0] offset_q;
	logic [3:0] index_q;
	logic       wr_alloc_q;
	logic       wr_back_q;

	// address split
	logic [AW-1:0]     addr_w;
	logic [4:0]        ib;
	logic [5:0]        shamt;
	logic [AW-1:0]     set_mask;
	logic [SET_AW-1:0] set_c;
	logic [AW-1:0]     tag_c;

	logic              is_write_s1;
	logic [SET_AW-1:0] set_s1;
	logic [AW-1:0]     tag_s1;

	logic [SET_AW-1:0] clr_q;

	// set RAM
	logic              rd_en, wr_en;
	logic [SET_AW-1:0] wr_addr;
	logic [RW-1:0]     rd_data, wr_data;
	row_t              row, new_row, clear_row;

	// lookup
	logic hit0, hit1, hit_c, hway, fill, vway, evict_c, memw_c, way_c;

	logic hit_q, way_q, evict_q, memw_q, done_q;
	twfct_event_t ev;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			two_way_q  <= 1'b1;
			offset_q   <= 5'd4;
			index_q    <= 4'd4;
			wr_alloc_q <= 1'b1;
			wr_back_q  <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_TWO_WAY:  two_way_q  <= cfg_data[0];
				CFG_OFFSET:   offset_q   <= cfg_data[4:0];
				CFG_INDEX:    index_q    <= cfg_data[3:0];
				CFG_WR_ALLOC: wr_alloc_q <= cfg_data[0];
				CFG_WR_BACK:  wr_back_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign addr_w   = AW'(address);
	assign ib       = (5'(index_q) > 5'(MAX_INDEX_BITS)) ? 5'(MAX_INDEX_BITS) : 5'(index_q);
	assign shamt    = 6'(offset_q) + 6'(ib);
	assign set_mask = (AW'(1) << ib) - AW'(1);
	assign set_c    = SET_AW'((addr_w >> offset_q) & set_mask);
	assign tag_c    = addr_w >> shamt;

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			is_write_s1 <= (cmd == CMD_WRITE);
			set_s1      <= set_c;
			tag_s1      <= tag_c;
		end
	end

	twfct_set_mem #(
		.AW(SET_AW),
		.DW(RW)
	) u_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (set_c),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	assign row = row_t'(rd_data);

	always_comb begin
		clear_row        = '0;
		clear_row.victim = 1'b1;
	end

	// compare and update of the set row
	always_comb begin
		hit0    = row.valid[0] && (row.tag[0] == tag_s1);
		hit1    = two_way_q && row.valid[1] && (row.tag[1] == tag_s1);
		hit_c   = hit0 || hit1;
		hway    = !hit0;
		fill    = !hit_c && (!is_write_s1 || wr_alloc_q);
		vway    = two_way_q ? row.victim : 1'b0;
		evict_c = fill && wr_back_q && row.valid[vway] && row.dirty[vway];
		memw_c  = is_write_s1 && (!wr_back_q || (!hit_c && !wr_alloc_q));
		way_c   = hit_c ? hway : (fill ? vway : 1'b0);

		new_row = row;
		if (hit_c && is_write_s1) begin
			new_row.dirty[hway] = 1'b1;
		end
		if (fill) begin
			new_row.tag[vway]   = tag_s1;
			new_row.valid[vway] = 1'b1;
			new_row.dirty[vway] = is_write_s1;
			new_row.victim      = ~vway;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_LOOK);
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + SET_AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOOK) begin
			hit_q   <= hit_c;
			way_q   <= way_c;
			evict_q <= evict_c;
			memw_q  <= memw_c;
		end
	end

	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		wr_en   = 1'b0;
		wr_addr = set_s1;
		wr_data = RW'(new_row);
		unique case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = RW'(clear_row);
				if (clr_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					rd_en   = 1'b1;
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				wr_en   = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		ev.fire     = (state_q == ST_LOOK);
		ev.is_write = is_write_s1;
		ev.hit      = hit_c;
		ev.evicted  = evict_c;
		ev.memw     = memw_c;
	end

	twfct_stats u_stats (
		.clk                (clk),
		.arst_n             (arst_n),
		.ev                 (ev),
		.read_hit_count     (read_hit_count),
		.write_hit_count    (write_hit_count),
		.read_miss_count    (read_miss_count),
		.write_miss_count   (write_miss_count),
		.writeback_count    (writeback_count),
		.memory_write_count (memory_write_count)
	);

	assign done          = done_q;
	assign hit           = hit_q;
	assign way_used      = way_q;
	assign evicted_dirty = evict_q;
	assign memory_write  = memw_q;

endmodule

FILE: src/twfct_set_mem.sv
// Set store: single-port-per-direction synchronous RAM, registered read.
module twfct_set_mem #(
	parameter int AW = 10,
	parameter int DW = 69
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data
);

	logic [DW-1:0] mem [(1 << AW)];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: src/twfct_stats.sv
// Saturating hit, miss, write-back and memory-write counters.
module twfct_stats
	import twfct_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  twfct_event_t ev,
	output logic [31:0]  read_hit_count,
	output logic [31:0]  write_hit_count,
	output logic [31:0]  read_miss_count,
	output logic [31:0]  write_miss_count,
	output logic [31:0]  writeback_count,
	output logic [31:0]  memory_write_count
);

	logic [31:0] rd_hit_q, wr_hit_q, rd_miss_q, wr_miss_q, wb_q, memw_q;
	logic        inc_rd_hit, inc_wr_hit, inc_rd_miss, inc_wr_miss;

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		return (v == '1) ? v : v + 32'd1;
	endfunction

	assign inc_rd_hit  = ev.fire &&  ev.hit && !ev.is_write;
	assign inc_wr_hit  = ev.fire &&  ev.hit &&  ev.is_write;
	assign inc_rd_miss = ev.fire && !ev.hit && !ev.is_write;
	assign inc_wr_miss = ev.fire && !ev.hit &&  ev.is_write;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_hit_q  <= '0;
			wr_hit_q  <= '0;
			rd_miss_q <= '0;
			wr_miss_q <= '0;
			wb_q      <= '0;
			memw_q    <= '0;
		end else begin
			if (inc_rd_hit)              rd_hit_q  <= sat_inc(rd_hit_q);
			if (inc_wr_hit)              wr_hit_q  <= sat_inc(wr_hit_q);
			if (inc_rd_miss)             rd_miss_q <= sat_inc(rd_miss_q);
			if (inc_wr_miss)             wr_miss_q <= sat_inc(wr_miss_q);
			if (ev.fire && ev.evicted)   wb_q      <= sat_inc(wb_q);
			if (ev.fire && ev.memw)      memw_q    <= sat_inc(memw_q);
		end
	end

	assign read_hit_count     = rd_hit_q;
	assign write_hit_count    = wr_hit_q;
	assign read_miss_count    = rd_miss_q;
	assign write_miss_count   = wr_miss_q;
	assign writeback_count    = wb_q;
	assign memory_write_count = memw_q;

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the two-way FIFO cache tracker.
module tb;
	import twfct_pkg::*;

	localparam int SET_BITS_MAX = 10;
	localparam int ROWS = 1 << SET_BITS_MAX;

	typedef struct packed {
		logic        cmd;
		logic [31:0] addr;
	} access_t;

	typedef struct packed {
		logic        hit;
		logic        way;
		logic        evicted;
		logic        memw;
		logic [31:0] rd_hits;
		logic [31:0] wr_hits;
		logic [31:0] rd_misses;
		logic [31:0] wr_misses;
		logic [31:0] writebacks;
		logic [31:0] mem_writes;
	} access_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic                  cmd = CMD_READ;
	logic [31:0]           address = '0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_TWO_WAY;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  done;
	logic                  hit;
	logic                  way_used;
	logic                  evicted_dirty;
	logic                  memory_write;
	logic [31:0]           read_hit_count;
	logic [31:0]           write_hit_count;
	logic [31:0]           read_miss_count;
	logic [31:0]           write_miss_count;
	logic [31:0]           writeback_count;
	logic [31:0]           memory_write_count;

	two_way_fifo_cache_tracker #(
		.MAX_INDEX_BITS(SET_BITS_MAX),
		.ADDRESS_WIDTH (32)
	) dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.busy              (busy),
		.cmd               (cmd),
		.address           (address),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.done              (done),
		.hit               (hit),
		.way_used          (way_used),
		.evicted_dirty     (evicted_dirty),
		.memory_write      (memory_write),
		.read_hit_count    (read_hit_count),
		.write_hit_count   (write_hit_count),
		.read_miss_count   (read_miss_count),
		.write_miss_count  (write_miss_count),
		.writeback_count   (writeback_count),
		.memory_write_count(memory_write_count)
	);

	always #2 clk = ~clk;

	// Shadow copy of the tag store, victim bits, counters and settings
	logic [31:0] tag_mem   [ROWS][2];
	logic        valid_mem [ROWS][2];
	logic        dirty_mem [ROWS][2];
	logic        victim_mem[ROWS];
	logic [31:0] rd_hit_tot, wr_hit_tot, rd_miss_tot, wr_miss_tot, wb_tot, memw_tot;
	logic        mode_two_way;
	logic [4:0]  offset_w;
	logic [3:0]  index_w;
	logic        alloc_on_write;
	logic        policy_wb;

	access_t        pending_accesses[$];
	access_result_t expected_results[$];

	int fail_cnt = 0;
	int accepted_cnt = 0;
	int checked_cnt = 0;
	int settings_cnt = 1;
	int hits_seen = 0;
	int evictions_seen = 0;
	int memw_seen = 0;
	int burst_left = 1;
	int gap_left = 0;

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	function automatic int clamped_index_w();
		return (index_w > SET_BITS_MAX) ? SET_BITS_MAX : int'(index_w);
	endfunction

	function automatic access_result_t predict_access(input logic is_wr, input logic [31:0] addr);
		logic [63:0]    a64;
		logic [63:0]    tag64;
		logic [31:0]    tag;
		int             ibc;
		int             row;
		int             w;
		logic           found;
		access_result_t r;
		a64 = {32'd0, addr};
		ibc = clamped_index_w();
		row = int'((a64 >> offset_w) & ((64'd1 << ibc) - 64'd1)) & (ROWS - 1);
		tag64 = a64 >> (int'(offset_w) + ibc);
		tag = tag64[31:0];
		found = 1'b0;
		w = 0;
		r = '0;
		if (valid_mem[row][0] && tag_mem[row][0] == tag) begin
			found = 1'b1;
			w = 0;
		end else if (mode_two_way && valid_mem[row][1] && tag_mem[row][1] == tag) begin
			found = 1'b1;
			w = 1;
		end
		if (found) begin
			if (is_wr) begin
				wr_hit_tot = sat_inc(wr_hit_tot);
				dirty_mem[row][w] = 1'b1;
			end else begin
				rd_hit_tot = sat_inc(rd_hit_tot);
			end
		end else begin
			if (is_wr)
				wr_miss_tot = sat_inc(wr_miss_tot);
			else
				rd_miss_tot = sat_inc(rd_miss_tot);
			if (!is_wr || alloc_on_write) begin
				w = mode_two_way ? int'(victim_mem[row]) : 0;
				// old dirty state of the victim is checked before the fill
				if (policy_wb && valid_mem[row][w] && dirty_mem[row][w]) begin
					r.evicted = 1'b1;
					wb_tot = sat_inc(wb_tot);
				end
				tag_mem[row][w] = tag;
				valid_mem[row][w] = 1'b1;
				dirty_mem[row][w] = is_wr;
				victim_mem[row] = (w == 0);
			end else begin
				w = 0;
			end
		end
		r.memw = is_wr && (!policy_wb || (!found && !alloc_on_write));
		if (r.memw)
			memw_tot = sat_inc(memw_tot);
		r.hit = found;
		r.way = (w == 1);
		r.rd_hits = rd_hit_tot;
		r.wr_hits = wr_hit_tot;
		r.rd_misses = rd_miss_tot;
		r.wr_misses = wr_miss_tot;
		r.writebacks = wb_tot;
		r.mem_writes = memw_tot;
		return r;
	endfunction

	// Mostly a small pool of tags over a few sets so lines get reused and evicted
	function automatic logic [31:0] gen_address();
		logic [63:0] a;
		int          ibc;
		ibc = clamped_index_w();
		if ($urandom_range(0, 4) == 0)
			return $urandom;
		a = 64'($urandom_range(0, 3)) << (int'(offset_w) + ibc);
		a |= (64'($urandom_range(0, 3)) & ((64'd1 << ibc) - 64'd1)) << offset_w;
		a |= 64'($urandom) & ((64'd1 << offset_w) - 64'd1);
		return a[31:0];
	endfunction

	task automatic push_access(input logic c, input logic [31:0] a);
		access_t item;
		item.cmd = c;
		item.addr = a;
		pending_accesses.push_back(item);
	endtask

	task automatic queue_random(input int n);
		for (int i = 0; i < n; i++)
			push_access($urandom_range(0, 1) ? CMD_WRITE : CMD_READ, gen_address());
	endtask

	task automatic drain();
		while (pending_accesses.size() != 0 || expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_TWO_WAY:  mode_two_way = val[0];
			CFG_OFFSET:   offset_w = val[4:0];
			CFG_INDEX:    index_w = val[3:0];
			CFG_WR_ALLOC: alloc_on_write = val[0];
			CFG_WR_BACK:  policy_wb = val[0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	task automatic apply_config(input logic tw, input int ob, input int ib, input logic wa,
			input logic wb);
		write_reg(CFG_TWO_WAY, CFG_DATA_W'(tw));
		write_reg(CFG_OFFSET, CFG_DATA_W'(ob));
		write_reg(CFG_INDEX, CFG_DATA_W'(ib));
		write_reg(CFG_WR_ALLOC, CFG_DATA_W'(wa));
		write_reg(CFG_WR_BACK, CFG_DATA_W'(wb));
		settings_cnt++;
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			fail_cnt++;
		end
	endtask

	// Sender: bursts of beats with random gaps; idle inputs carry junk
	always @(posedge clk) begin : drive_beats
		logic took;
		logic go;
		took = arst_n && start && !busy;
		if (took) begin
			expected_results.push_back(predict_access(pending_accesses[0].cmd,
				pending_accesses[0].addr));
			pending_accesses.pop_front();
			accepted_cnt++;
			burst_left--;
			if (burst_left <= 0) begin
				burst_left = $urandom_range(1, 30);
				gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
			end
		end else if (gap_left > 0) begin
			gap_left--;
		end
		go = arst_n && gap_left == 0 && pending_accesses.size() != 0;
		start <= go;
		if (go) begin
			cmd <= pending_accesses[0].cmd;
			address <= pending_accesses[0].addr;
		end else begin
			cmd <= $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
			address <= $urandom;
		end
	end

	always @(posedge clk) begin : check_results
		access_result_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$display("%0t: result with no access pending, actual hit %0b way %0b",
					$time, hit, way_used);
				fail_cnt++;
			end else begin
				want = expected_results.pop_front();
				check_field("hit", 32'(want.hit), 32'(hit));
				check_field("way_used", 32'(want.way), 32'(way_used));
				check_field("evicted_dirty", 32'(want.evicted), 32'(evicted_dirty));
				check_field("memory_write", 32'(want.memw), 32'(memory_write));
				check_field("read_hit_count", want.rd_hits, read_hit_count);
				check_field("write_hit_count", want.wr_hits, write_hit_count);
				check_field("read_miss_count", want.rd_misses, read_miss_count);
				check_field("write_miss_count", want.wr_misses, write_miss_count);
				check_field("writeback_count", want.writebacks, writeback_count);
				check_field("memory_write_count", want.mem_writes, memory_write_count);
				checked_cnt++;
				hits_seen += int'(want.hit);
				evictions_seen += int'(want.evicted);
				memw_seen += int'(want.memw);
			end
		end
	end

	initial begin
		#400000;
		$display("two_way_fifo_cache_tracker regression: fail");
		$finish;
	end

	initial begin
		for (int i = 0; i < ROWS; i++) begin
			for (int j = 0; j < 2; j++) begin
				tag_mem[i][j] = '0;
				valid_mem[i][j] = 1'b0;
				dirty_mem[i][j] = 1'b0;
			end
			victim_mem[i] = 1'b1;
		end
		{rd_hit_tot, wr_hit_tot, rd_miss_tot, wr_miss_tot, wb_tot, memw_tot} = '0;
		mode_two_way = 1'b1;
		offset_w = 5'd4;
		index_w = 4'd4;
		alloc_on_write = 1'b1;
		policy_wb = 1'b1;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// set store clearing pass
		while (busy) @(posedge clk);

		// reset settings: fill order, hits, dirty victims, address extremes
		push_access(CMD_READ, 32'h0000_0100);
		push_access(CMD_READ, 32'h0000_010C);
		push_access(CMD_WRITE, 32'h0000_0104);
		push_access(CMD_WRITE, 32'h0000_0200);
		push_access(CMD_READ, 32'h0000_0300);
		push_access(CMD_READ, 32'h0000_0400);
		push_access(CMD_READ, 32'h0000_0000);
		push_access(CMD_READ, 32'hFFFF_FFFF);
		push_access(CMD_WRITE, 32'hFFFF_FFFF);
		push_access(CMD_READ, 32'h8000_0000);
		push_access(CMD_WRITE, 32'h7FFF_FFF0);
		push_access(CMD_WRITE, 32'h0000_0000);
		push_access(CMD_READ, 32'h5555_5555);
		push_access(CMD_WRITE, 32'hAAAA_AAAA);
		queue_random(50);
		drain();

		apply_config(1'b0, 4, 4, 1'b1, 1'b1);
		queue_random(60);
		drain();

		// write-through without allocate: bypassing miss, then fill, then hit
		apply_config(1'b1, 4, 4, 1'b0, 1'b0);
		push_access(CMD_WRITE, 32'h0000_05A0);
		push_access(CMD_READ, 32'h0000_05A0);
		push_access(CMD_WRITE, 32'h0000_05A4);
		queue_random(55);
		drain();

		apply_config(1'b1, 0, 0, 1'b1, 1'b0);
		queue_random(55);
		drain();

		apply_config(1'b1, 16, 10, 1'b0, 1'b1);
		push_access(CMD_WRITE, 32'h1234_0000);
		queue_random(55);
		drain();

		apply_config(1'b0, 31, 15, 1'b1, 1'b1);
		queue_random(55);
		drain();

		// same mapping as the direct phase, so both ways can hold one tag
		apply_config(1'b1, 4, 4, 1'b1, 1'b1);
		queue_random(60);
		drain();

		apply_config(1'b1, 4, 11, 1'b1, 1'b0);
		queue_random(55);
		drain();

		for (int p = 0; p < 3; p++) begin
			apply_config(1'($urandom_range(0, 1)), $urandom_range(0, 31),
				$urandom_range(0, 15), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)));
			queue_random(50);
			drain();
		end

		repeat (10) @(posedge clk);
		$display("%0d accesses under %0d cache settings, %0d results checked",
			accepted_cnt, settings_cnt, checked_cnt);
		$display("%0d hits, %0d dirty evictions, %0d memory writes seen",
			hits_seen, evictions_seen, memw_seen);
		if (fail_cnt == 0) begin
			$display("two_way_fifo_cache_tracker regression: pass");
		end else begin
			$display("two_way_fifo_cache_tracker regression: fail");
		end
		$finish;
	end

endmodule
